### hw/rtl/ptwt_pkg.sv
// ----------------------------------------------------------------------------
// ptwt_pkg: shared definitions of the page table walker
// Operation, status and size codes, memory geometry, controller states, the
// command and status groups between controller and datapath, and helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package ptwt_pkg;

   // Geometry of the local table memory
   localparam int TABLE_COUNT       = 8;
   localparam int ENTRIES_PER_TABLE = 512;
   localparam int MEM_WORDS         = TABLE_COUNT * ENTRIES_PER_TABLE;
   localparam int MEM_AW            = $clog2(MEM_WORDS);

   // Field widths
   localparam int OP_W   = 2;
   localparam int VA_W   = 48;
   localparam int WIDX_W = 12;
   localparam int WORD_W = 64;
   localparam int PA_W   = 52;
   localparam int SIZE_W = 2;
   localparam int STAT_W = 2;
   localparam int ROOT_W = 3;
   localparam int IDX_W  = 9;
   localparam int TBL_W  = 40;   // page number field, bits 51:12 of an entry
   localparam int LVL_W  = 2;

   // Entry bits
   localparam int BIT_PRESENT = 0;
   localparam int BIT_HUGE    = 7;

   // Operation codes
   localparam logic [OP_W-1:0] OP_WRITE     = 2'd0;
   localparam logic [OP_W-1:0] OP_TRANSLATE = 2'd1;
   localparam logic [OP_W-1:0] OP_UNMAP     = 2'd2;

   // Status codes
   localparam logic [STAT_W-1:0] STAT_OK          = 2'd0;
   localparam logic [STAT_W-1:0] STAT_NOT_PRESENT = 2'd1;
   localparam logic [STAT_W-1:0] STAT_HUGE        = 2'd2;
   localparam logic [STAT_W-1:0] STAT_OUTSIDE     = 2'd3;

   // Page size codes
   localparam logic [SIZE_W-1:0] SIZE_4K = 2'd0;
   localparam logic [SIZE_W-1:0] SIZE_2M = 2'd1;
   localparam logic [SIZE_W-1:0] SIZE_1G = 2'd2;

   // Walk levels
   localparam logic [LVL_W-1:0] LVL_ROOT = 2'd0;
   localparam logic [LVL_W-1:0] LVL_PDPT = 2'd1;
   localparam logic [LVL_W-1:0] LVL_DIR  = 2'd2;
   localparam logic [LVL_W-1:0] LVL_LEAF = 2'd3;

   typedef logic [MEM_AW-1:0] mem_addr_type;

   typedef enum logic [2:0] {
      CS_CLEAR,
      CS_IDLE,
      CS_WALK,
      CS_UNMAP,
      CS_DONE
   } ctl_state_type;

   // Controller to datapath
   typedef struct packed {
      logic clear_step;   // zero one memory word of the clearing pass
      logic accept;       // take the input beat
      logic walk_step;    // evaluate the entry just read
      logic clear_leaf;   // zero the 4KB leaf found by an unmap
      logic load_rsp;     // move the result into the output register
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clear_last;   // clearing pass at its final word
      logic start_walk;   // input beat is a walk with the root in the window
      logic walk_end;     // entry just read finishes the walk
      logic leaf_clear;   // finished walk is an unmap of a present 4KB leaf
      logic rsp_free;     // output register can take a result
   } dp_status_type;

   // Word position of entry idx in local table tbl
   function automatic mem_addr_type table_addr(logic [TBL_W-1:0] tbl,
                                               logic [IDX_W-1:0] idx);
      logic [TBL_W+IDX_W-1:0] full;
      full = {tbl, idx};
      return full[MEM_AW-1:0];
   endfunction

   // Nine index bits of the virtual address for one level
   function automatic logic [IDX_W-1:0] va_index(logic [VA_W-1:0] va,
                                                 logic [LVL_W-1:0] lvl);
      logic [IDX_W-1:0] idx;
      unique case (lvl)
         LVL_ROOT: idx = va[47:39];
         LVL_PDPT: idx = va[38:30];
         LVL_DIR:  idx = va[29:21];
         default:  idx = va[20:12];
      endcase
      return idx;
   endfunction

   // Physical address of a leaf entry
   function automatic logic [PA_W-1:0] leaf_address(logic [WORD_W-1:0] e,
                                                    logic [SIZE_W-1:0] size,
                                                    logic [VA_W-1:0] va);
      logic [PA_W-1:0] pa;
      priority if (size == SIZE_1G) begin
         pa = {e[51:30], va[29:0]};
      end else if (size == SIZE_2M) begin
         pa = {e[51:21], va[20:0]};
      end else begin
         pa = {e[51:12], va[11:0]};
      end
      return pa;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/ptwt_ctrl.sv
// ----------------------------------------------------------------------------
// ptwt_ctrl: sequencer of the page table walker
// Runs the clearing pass after reset, takes input beats, steps the walk one
// level a cycle, schedules the unmap write-back and hands results out.
// ----------------------------------------------------------------------------
`default_nettype none

module ptwt_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_stall,
   output ptwt_pkg::dp_cmd_type    cmd,
   input  ptwt_pkg::dp_status_type stat
);
   import ptwt_pkg::*;

   ctl_state_type state_ff;
   ctl_state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         CS_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) begin
               state_in = CS_IDLE;
            end
         end
         CS_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = stat.start_walk ? CS_WALK : CS_DONE;
            end
         end
         CS_WALK: begin
            cmd.walk_step = 1'b1;
            if (stat.walk_end) begin
               state_in = stat.leaf_clear ? CS_UNMAP : CS_DONE;
            end
         end
         CS_UNMAP: begin
            cmd.clear_leaf = 1'b1;
            state_in       = CS_DONE;
         end
         CS_DONE: begin
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_CLEAR;
         end
      endcase
   end

endmodule

`default_nettype wire

### hw/rtl/ptwt_dpath.sv
// ----------------------------------------------------------------------------
// ptwt_dpath: datapath of the page table walker
// Table memory with its clearing counter, root register, walk registers,
// entry checks, pending result and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ptwt_dpath (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   csr_write_enable,
   input  wire  [ptwt_pkg::ROOT_W-1:0]           csr_write_data,
   input  wire  [ptwt_pkg::OP_W-1:0]             req_operation,
   input  wire  [ptwt_pkg::VA_W-1:0]             req_virtual_address,
   input  wire  [ptwt_pkg::WIDX_W-1:0]           req_table_word_index,
   input  wire  [ptwt_pkg::WORD_W-1:0]           req_entry_value,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic [ptwt_pkg::PA_W-1:0]             rsp_physical_address,
   output logic [ptwt_pkg::SIZE_W-1:0]           rsp_page_size,
   output logic [ptwt_pkg::STAT_W-1:0]           rsp_status,
   input  ptwt_pkg::dp_cmd_type                  cmd,
   output ptwt_pkg::dp_status_type               stat
);
   import ptwt_pkg::*;

   logic [WORD_W-1:0] mem [MEM_WORDS];

   logic [ROOT_W-1:0] root_ff;
   logic [OP_W-1:0]   op_ff;
   logic [VA_W-1:0]   va_ff;
   logic [LVL_W-1:0]  level_ff;
   logic [LVL_W-1:0]  level_in;
   mem_addr_type      addr_ff;
   mem_addr_type      addr_in;
   mem_addr_type      clr_ff;
   logic [WORD_W-1:0] rd_ff;

   logic [PA_W-1:0]   res_pa_ff;
   logic [PA_W-1:0]   res_pa_in;
   logic [SIZE_W-1:0] res_size_ff;
   logic [SIZE_W-1:0] res_size_in;
   logic [STAT_W-1:0] res_status_ff;
   logic [STAT_W-1:0] res_status_in;

   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [PA_W-1:0]   rsp_pa_ff;
   logic [SIZE_W-1:0] rsp_size_ff;
   logic [STAT_W-1:0] rsp_status_ff;

   logic              mem_we;
   mem_addr_type      mem_wa;
   logic [WORD_W-1:0] mem_wd;
   mem_addr_type      mem_ra;

   logic              wr_ok;
   logic              root_ok;
   logic              req_is_walk;
   logic [TBL_W-1:0]  root_tbl;
   logic [31:0]       widx_ext;

   logic              e_present;
   logic              e_huge;
   logic              e_leaf;
   logic [SIZE_W-1:0] e_size;
   logic [TBL_W-1:0]  next_tbl;
   logic              next_ok;
   logic              huge_refused;

   // Configuration register and control state
   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff      <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            root_ff <= csr_write_data;
         end
         if (cmd.clear_step) begin
            clr_ff <= clr_ff + 1'b1;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Checks on the input beat
   always_comb begin
      widx_ext    = 32'(req_table_word_index);
      wr_ok       = widx_ext < 32'(MEM_WORDS);
      root_tbl    = TBL_W'(root_ff);
      root_ok     = root_tbl < TBL_W'(TABLE_COUNT);
      req_is_walk = (req_operation == OP_TRANSLATE) || (req_operation == OP_UNMAP);
   end

   // Decode the entry just read
   always_comb begin
      e_present = rd_ff[BIT_PRESENT];
      e_huge    = rd_ff[BIT_HUGE] && ((level_ff == LVL_PDPT) || (level_ff == LVL_DIR));
      e_leaf    = e_present && (e_huge || (level_ff == LVL_LEAF));
      unique case (level_ff)
         LVL_PDPT: e_size = SIZE_1G;
         LVL_DIR:  e_size = SIZE_2M;
         default:  e_size = SIZE_4K;
      endcase
      next_tbl     = rd_ff[51:12];
      next_ok      = next_tbl < TBL_W'(TABLE_COUNT);
      huge_refused = (op_ff == OP_UNMAP) && (e_size != SIZE_4K);
   end

   // Status towards the controller
   always_comb begin
      stat.clear_last = clr_ff == MEM_AW'(MEM_WORDS - 1);
      stat.start_walk = req_is_walk && root_ok;
      stat.walk_end   = !e_present || e_leaf || !next_ok;
      stat.leaf_clear = e_leaf && (op_ff == OP_UNMAP) && (e_size == SIZE_4K);
      stat.rsp_free   = !rsp_valid_ff || !rsp_stall;
   end

   // Walk position and pending result
   always_comb begin
      level_in      = level_ff;
      addr_in       = addr_ff;
      res_pa_in     = res_pa_ff;
      res_size_in   = res_size_ff;
      res_status_in = res_status_ff;
      if (cmd.accept) begin
         level_in      = LVL_ROOT;
         addr_in       = table_addr(root_tbl, va_index(req_virtual_address, LVL_ROOT));
         res_pa_in     = '0;
         res_size_in   = SIZE_4K;
         res_status_in = STAT_OK;
         if (req_operation == OP_WRITE) begin
            res_status_in = wr_ok ? STAT_OK : STAT_OUTSIDE;
         end else if (req_is_walk && !root_ok) begin
            res_status_in = STAT_OUTSIDE;
         end
      end else if (cmd.walk_step) begin
         level_in = level_ff + 1'b1;
         addr_in  = table_addr(next_tbl, va_index(va_ff, level_in));
         priority if (!e_present) begin
            res_status_in = STAT_NOT_PRESENT;
         end else if (e_leaf && huge_refused) begin
            res_status_in = STAT_HUGE;
            res_size_in   = e_size;
            addr_in       = addr_ff;
         end else if (e_leaf) begin
            res_status_in = STAT_OK;
            res_size_in   = e_size;
            res_pa_in     = leaf_address(rd_ff, e_size, va_ff);
            addr_in       = addr_ff;
         end else if (!next_ok) begin
            res_status_in = STAT_OUTSIDE;
         end else begin
            res_status_in = STAT_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff <= req_operation;
         va_ff <= req_virtual_address;
      end
      level_ff      <= level_in;
      addr_ff       <= addr_in;
      res_pa_ff     <= res_pa_in;
      res_size_ff   <= res_size_in;
      res_status_ff <= res_status_in;
   end

   // Memory port selection
   always_comb begin
      mem_we = 1'b0;
      mem_wa = clr_ff;
      mem_wd = '0;
      priority if (cmd.clear_step) begin
         mem_we = 1'b1;
      end else if (cmd.clear_leaf) begin
         mem_we = 1'b1;
         mem_wa = addr_ff;
      end else if (cmd.accept && (req_operation == OP_WRITE) && wr_ok) begin
         mem_we = 1'b1;
         mem_wa = widx_ext[MEM_AW-1:0];
         mem_wd = req_entry_value;
      end
      mem_ra = addr_in;
   end

   // Table memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_ff <= mem[mem_ra];
   end

   // Output register: hold while stalled, drop once taken
   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_pa_ff     <= res_pa_ff;
         rsp_size_ff   <= res_size_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_physical_address = rsp_pa_ff;
   assign rsp_page_size        = rsp_size_ff;
   assign rsp_status           = rsp_status_ff;

endmodule

`default_nettype wire

### hw/rtl/page_table_walk_translate_core.sv
// ----------------------------------------------------------------------------
// page_table_walk_translate_core: four-level page walker over local tables
// Top level joining the sequencer and the datapath.
// ----------------------------------------------------------------------------
// After reset the block zeroes its table memory of MEM_WORDS words (4096 with
// eight tables), one word a cycle; it takes no beat meanwhile, while root
// table writes on the csr port are taken at any time. One item is worked at a
// time. A write goes from acceptance straight to the done state; a walk reads
// one level per cycle from the table memory (one write port and one registered
// read port), from the root table down to a leaf or a fault, and an unmap of a
// 4KB page adds a write-back state before the done state. The next beat is
// taken in the cycle after a result enters the output register, which holds it
// until the receiver lets it go.
// ----------------------------------------------------------------------------
`default_nettype none

module page_table_walk_translate_core (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              csr_write_enable,
   input  wire  [ptwt_pkg::ROOT_W-1:0]      csr_write_data,
   input  wire                              req_valid,
   output logic                             req_stall,
   input  wire  [ptwt_pkg::OP_W-1:0]        req_operation,
   input  wire  [ptwt_pkg::VA_W-1:0]        req_virtual_address,
   input  wire  [ptwt_pkg::WIDX_W-1:0]      req_table_word_index,
   input  wire  [ptwt_pkg::WORD_W-1:0]      req_entry_value,
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output logic [ptwt_pkg::PA_W-1:0]        rsp_physical_address,
   output logic [ptwt_pkg::SIZE_W-1:0]      rsp_page_size,
   output logic [ptwt_pkg::STAT_W-1:0]      rsp_status
);
   import ptwt_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type stat;

   // Sequencer
   ptwt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   // Datapath
   ptwt_dpath u_dpath (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data),
      .req_operation        (req_operation),
      .req_virtual_address  (req_virtual_address),
      .req_table_word_index (req_table_word_index),
      .req_entry_value      (req_entry_value),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_physical_address (rsp_physical_address),
      .rsp_page_size        (rsp_page_size),
      .rsp_status           (rsp_status),
      .cmd                  (cmd),
      .stat                 (stat)
   );

endmodule

`default_nettype wire

### tb/page_table_walk_translate_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_table_walk_translate_core_test: self-checking bench of the page walker
// Builds four-level mappings in the local table memory through write beats,
// then translates and unmaps through them under random idling on both
// channels, across several root table settings. A shadow of the tables and
// of the root register predicts every result, which is checked field by field.
// ----------------------------------------------------------------------------

module page_table_walk_translate_core_test;
   import ptwt_pkg::*;

   localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;
   localparam int HANG_LIMIT = 20000;

   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [VA_W-1:0]   vaddr;
      logic [WIDX_W-1:0] word_index;
      logic [WORD_W-1:0] entry;
   } walk_request_t;

   typedef struct packed {
      logic [PA_W-1:0]   phys_addr;
      logic [SIZE_W-1:0] leaf_size;
      logic [STAT_W-1:0] status;
   } walk_outcome_t;

   logic                clock;
   logic                reset = 1'b1;
   logic                csr_write_enable = 1'b0;
   logic [ROOT_W-1:0]   csr_write_data = '0;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [OP_W-1:0]     req_operation = '0;
   logic [VA_W-1:0]     req_virtual_address = '0;
   logic [WIDX_W-1:0]   req_table_word_index = '0;
   logic [WORD_W-1:0]   req_entry_value = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [PA_W-1:0]     rsp_physical_address;
   logic [SIZE_W-1:0]   rsp_page_size;
   logic [STAT_W-1:0]   rsp_status;

   // Shadow of the block: table words and root register
   logic [WORD_W-1:0]   shadow_tables [0:MEM_WORDS-1];
   logic [ROOT_W-1:0]   shadow_root = '0;

   walk_request_t       pending_requests [$];
   walk_outcome_t       predicted_walks [$];
   walk_request_t       driven_request;
   int                  requests_issued = 0;
   int                  results_seen = 0;
   int                  mismatch_count = 0;
   int                  idle_pct = 20;
   int                  hang_cycles = 0;

   page_table_walk_translate_core u_dut (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_operation        (req_operation),
      .req_virtual_address  (req_virtual_address),
      .req_table_word_index (req_table_word_index),
      .req_entry_value      (req_entry_value),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_physical_address (rsp_physical_address),
      .rsp_page_size        (rsp_page_size),
      .rsp_status           (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatch_count++;
      $display("%0t mismatch: %s got %h want %h", $time, what, got, want);
   endtask

   // Apply one beat to the shadow tables and return the result it must give
   function automatic walk_outcome_t predict_walk(walk_request_t rq);
      walk_outcome_t     res;
      logic [TBL_W-1:0]  tbl_num;
      logic [VA_W-1:0]   shifted;
      logic [IDX_W-1:0]  idx;
      logic [WIDX_W-1:0] pos;
      logic [WORD_W-1:0] e;
      logic [PA_W-1:0]   base;
      logic [SIZE_W-1:0] found_size;
      logic              done;
      res = '0;
      if (rq.operation == OP_WRITE) begin
         if (rq.word_index < MEM_WORDS) begin
            shadow_tables[rq.word_index] = rq.entry;
         end else begin
            res.status = STAT_OUTSIDE;
         end
      end else if (rq.operation == OP_TRANSLATE || rq.operation == OP_UNMAP) begin
         tbl_num = TBL_W'(shadow_root);
         done = 1'b0;
         found_size = SIZE_4K;
         pos = '0;
         e = '0;
         // Descend one level per pass until a leaf or a fault
         for (int lvl = 0; lvl < 4 && !done; lvl++) begin
            shifted = rq.vaddr >> (39 - 9 * lvl);
            idx = shifted[IDX_W-1:0];
            if (tbl_num >= TABLE_COUNT) begin
               res.status = STAT_OUTSIDE;
               done = 1'b1;
            end else begin
               pos = {tbl_num[2:0], idx};
               e = shadow_tables[pos];
               if (!e[BIT_PRESENT]) begin
                  res.status = STAT_NOT_PRESENT;
                  done = 1'b1;
               end else if (lvl == 1 && e[BIT_HUGE]) begin
                  found_size = SIZE_1G;
                  done = 1'b1;
               end else if (lvl == 2 && e[BIT_HUGE]) begin
                  found_size = SIZE_2M;
                  done = 1'b1;
               end else if (lvl == 3) begin
                  found_size = SIZE_4K;
                  done = 1'b1;
               end else begin
                  tbl_num = e[51:12];
               end
            end
         end
         if (res.status == STAT_OK) begin
            res.leaf_size = found_size;
            if (rq.operation == OP_UNMAP && found_size != SIZE_4K) begin
               res.status = STAT_HUGE;
            end else begin
               base = e[PA_W-1:0] & 52'hF_FFFF_FFFF_F000;
               if (found_size == SIZE_1G) begin
                  res.phys_addr = (base & ~52'h3FFF_FFFF) | {22'd0, rq.vaddr[29:0]};
               end else if (found_size == SIZE_2M) begin
                  res.phys_addr = (base & ~52'h1F_FFFF) | {31'd0, rq.vaddr[20:0]};
               end else begin
                  res.phys_addr = base | {40'd0, rq.vaddr[11:0]};
               end
               if (rq.operation == OP_UNMAP) begin
                  shadow_tables[pos] = '0;
               end
            end
         end
      end
      return res;
   endfunction

   // Request driver: hold a stalled beat, otherwise load the next or idle
   always @(posedge clock) begin : drive_requests
      logic send_next;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predicted_walks.push_back(predict_walk(driven_request));
         end
         if (!req_valid || !req_stall) begin
            send_next = pending_requests.size() != 0 && $urandom_range(0, 99) >= idle_pct;
            if (send_next) begin
               driven_request = pending_requests.pop_front();
               req_operation <= driven_request.operation;
               req_virtual_address <= driven_request.vaddr;
               req_table_word_index <= driven_request.word_index;
               req_entry_value <= driven_request.entry;
            end
            req_valid <= send_next;
         end
      end
   end

   // Result monitor: check each accepted beat against the oldest prediction
   always @(posedge clock) begin : watch_results
      walk_outcome_t want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (predicted_walks.size() == 0) begin
               report_mismatch("result with nothing predicted",
                               64'(rsp_physical_address), '0);
            end else begin
               want = predicted_walks.pop_front();
               if (rsp_physical_address !== want.phys_addr)
                  report_mismatch("physical_address", 64'(rsp_physical_address),
                                  64'(want.phys_addr));
               if (rsp_page_size !== want.leaf_size)
                  report_mismatch("leaf size", 64'(rsp_page_size), 64'(want.leaf_size));
               if (rsp_status !== want.status)
                  report_mismatch("status", 64'(rsp_status), 64'(want.status));
            end
         end
         rsp_stall <= $urandom_range(0, 99) < idle_pct;
      end
   end

   // Watchdog: drop the run once no beat has moved for too long
   always @(posedge clock) begin : watchdog
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         hang_cycles <= 0;
      end else begin
         hang_cycles <= hang_cycles + 1;
      end
      if (hang_cycles >= HANG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic void push_request(logic [OP_W-1:0] op, logic [VA_W-1:0] va,
                                        logic [WIDX_W-1:0] widx,
                                        logic [WORD_W-1:0] value);
      walk_request_t rq;
      rq.operation = op;
      rq.vaddr = va;
      rq.word_index = widx;
      rq.entry = value;
      pending_requests.push_back(rq);
      requests_issued++;
   endfunction

   function automatic void push_write(logic [WIDX_W-1:0] widx, logic [WORD_W-1:0] value);
      logic [63:0] r;
      r = rand64();
      push_request(OP_WRITE, r[VA_W-1:0], widx, value);
   endfunction

   function automatic void push_walk(logic [OP_W-1:0] op, logic [VA_W-1:0] va);
      push_request(op, va, WIDX_W'($urandom_range(0, 4095)), rand64());
   endfunction

   // Table entry with random flag and upper bits around the given fields
   function automatic logic [WORD_W-1:0] make_entry(logic [TBL_W-1:0] pfn, logic present,
                                                     logic huge);
      logic [WORD_W-1:0] e;
      e = rand64();
      e[51:12] = pfn;
      e[BIT_PRESENT] = present;
      e[BIT_HUGE] = huge;
      return e;
   endfunction

   // Mostly a table in the window, now and then one beyond it
   function automatic logic [TBL_W-1:0] pick_table();
      logic [63:0]      r;
      logic [TBL_W-1:0] t;
      r = rand64();
      if ($urandom_range(0, 15) == 0) begin
         t = r[TBL_W-1:0] | TBL_W'(8);
      end else begin
         t = TBL_W'($urandom_range(0, TABLE_COUNT - 1));
      end
      return t;
   endfunction

   // Build a chain of entries for a random address, then walk through it
   function automatic void map_and_probe();
      logic [63:0]       r;
      logic [VA_W-1:0]   va;
      logic [SIZE_W-1:0] kind;
      logic [TBL_W-1:0]  t1;
      logic [TBL_W-1:0]  t2;
      logic [TBL_W-1:0]  t3;
      r = rand64();
      va = r[VA_W-1:0];
      kind = SIZE_W'($urandom_range(0, 2));
      t1 = pick_table();
      push_write({shadow_root, va[47:39]},
                 make_entry(t1, $urandom_range(0, 11) != 0, 1'($urandom_range(0, 1))));
      if (t1 < TABLE_COUNT) begin
         if (kind == SIZE_1G) begin
            r = rand64();
            push_write({t1[2:0], va[38:30]},
                       make_entry(r[TBL_W-1:0], $urandom_range(0, 11) != 0, 1'b1));
         end else begin
            t2 = pick_table();
            push_write({t1[2:0], va[38:30]},
                       make_entry(t2, $urandom_range(0, 11) != 0, 1'b0));
            if (t2 < TABLE_COUNT) begin
               if (kind == SIZE_2M) begin
                  r = rand64();
                  push_write({t2[2:0], va[29:21]},
                             make_entry(r[TBL_W-1:0], $urandom_range(0, 11) != 0, 1'b1));
               end else begin
                  t3 = pick_table();
                  push_write({t2[2:0], va[29:21]},
                             make_entry(t3, $urandom_range(0, 11) != 0, 1'b0));
                  if (t3 < TABLE_COUNT) begin
                     r = rand64();
                     push_write({t3[2:0], va[20:12]},
                                make_entry(r[TBL_W-1:0], $urandom_range(0, 11) != 0,
                                           1'($urandom_range(0, 1))));
                  end
               end
            end
         end
      end
      push_walk(OP_TRANSLATE, va);
      push_walk(OP_TRANSLATE, {va[47:12], 12'($urandom_range(0, 4095))});
      if ($urandom_range(0, 1) == 1) begin
         push_walk(OP_UNMAP, va);
         push_walk(OP_TRANSLATE, va);
      end
   endfunction

   // Fully random beats of any operation
   function automatic void scatter_noise();
      logic [63:0] r;
      repeat ($urandom_range(1, 3)) begin
         r = rand64();
         push_request(OP_W'($urandom_range(0, 3)), r[VA_W-1:0],
                      WIDX_W'($urandom_range(0, 4095)), rand64());
      end
   endfunction

   task automatic wait_drain();
      while (results_seen != requests_issued) @(posedge clock);
   endtask

   task automatic write_root(input logic [ROOT_W-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      shadow_root = value;
   endtask

   task automatic run_phase(input logic [ROOT_W-1:0] root, input int pct, input int count);
      int target;
      write_root(root);
      idle_pct = pct;
      target = requests_issued + count;
      while (requests_issued < target) begin
         if ($urandom_range(0, 4) == 0) begin
            scatter_noise();
         end else begin
            map_and_probe();
         end
      end
      wait_drain();
   endtask

   initial begin : run_test
      foreach (shadow_tables[i]) shadow_tables[i] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed beats against root table 0, taken once the clearing pass ends
      write_root(3'd0);
      push_walk(OP_TRANSLATE, 48'h0);                      // cleared memory
      push_request(OP_RESERVED, 48'hFFFF_FFFF_FFFF, 12'hFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      push_write(12'h000, 64'h0000_0000_0000_1081);       // huge bit ignored at root
      push_write(12'h200, 64'h0000_0000_0000_9001);       // points past the window
      push_walk(OP_TRANSLATE, 48'h0);
      push_write(12'h200, 64'hFFFF_FFFF_FFFF_F081);       // 1GB leaf
      push_walk(OP_TRANSLATE, 48'h0000_1234_5678);
      push_walk(OP_UNMAP, 48'h0);                          // refuse a 1GB unmap
      push_write(12'h201, 64'h0000_0000_0000_2001);
      push_write(12'h400, 64'h800A_BCDE_F12F_F083);       // 2MB leaf
      push_walk(OP_TRANSLATE, 48'h0000_401F_FFFF);
      push_walk(OP_UNMAP, 48'h0000_4000_0000);             // refuse a 2MB unmap
      push_write(12'h401, 64'h0000_0000_0000_3001);
      push_write(12'h7FF, 64'h7FFF_FFFF_FFFF_F0FF);       // 4KB leaf, attribute bit set
      push_walk(OP_TRANSLATE, 48'h0000_403F_FFFF);
      push_walk(OP_UNMAP, 48'h0000_403F_F000);
      push_walk(OP_TRANSLATE, 48'h0000_403F_FFFF);         // gone after unmap
      push_walk(OP_UNMAP, 48'h0000_403F_F000);
      push_write(12'hFFF, 64'hFFFF_FFFF_FFFF_FFFF);       // last word of the memory
      push_write(12'h1FF, 64'h0000_0000_0000_7001);
      push_walk(OP_TRANSLATE, 48'hFFFF_FFFF_FFFF);
      push_write(12'h202, 64'h000F_FFFF_FFFF_F001);       // very large table number
      push_walk(OP_TRANSLATE, 48'h0000_8000_0000);
      push_walk(OP_TRANSLATE, 48'h0000_4040_0000);         // absent directory entry
      wait_drain();

      // Random mappings under several root settings, one with no idling
      run_phase(3'd7, 20, 170);
      run_phase(3'd3, 0, 130);
      run_phase(ROOT_W'($urandom_range(1, 6)), 20, 170);
      run_phase(3'd0, 20, 180);

      repeat (20) @(posedge clock);
      if (predicted_walks.size() != 0)
         report_mismatch("predictions left over", 64'(predicted_walks.size()), '0);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
